[src/lpht_pkg.sv]
package lpht_pkg;

	localparam int TABLE_SIZE = 32;
	localparam int IDX_W      = $clog2(TABLE_SIZE);

	localparam int OP_W   = 2;
	localparam int KEY_W  = 16;
	localparam int VAL_W  = 32;
	localparam int ST_W   = 2;
	localparam int SLOT_W = 5;

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

	localparam logic [ST_W-1:0] ST_OK   = 2'd0;
	localparam logic [ST_W-1:0] ST_MISS = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL = 2'd2;

	typedef logic [OP_W-1:0]   opcode_t;
	typedef logic [KEY_W-1:0]  key_t;
	typedef logic [VAL_W-1:0]  value_t;
	typedef logic [ST_W-1:0]   status_t;
	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [IDX_W-1:0]  idx_t;

	// one table slot as held in the RAM; emptiness lives in the valid flops
	typedef struct packed {
		logic   tomb;
		key_t   key;
		value_t value;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

[src/lpht_req_if.sv]
interface lpht_req_if;
	import lpht_pkg::*;

	logic    valid;
	logic    ready;
	opcode_t opcode;
	key_t    search_key;
	value_t  entry_value;

	modport source (output valid, output opcode, output search_key, output entry_value,
		input ready);
	modport sink (input valid, input opcode, input search_key, input entry_value,
		output ready);

endinterface

[src/lpht_rsp_if.sv]
interface lpht_rsp_if;
	import lpht_pkg::*;

	logic    valid;
	logic    ready;
	status_t status;
	value_t  found_value;
	slot_t   slot_index;

	modport source (output valid, output status, output found_value, output slot_index,
		input ready);
	modport sink (input valid, input status, input found_value, input slot_index,
		output ready);

endinterface

[src/lpht_ram.sv]
module lpht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[src/linear_probe_hash_table.sv]
// Flow: a taken word reads its home slot in the lookup state, then probe states check one slot
// each, p = slots probed (1..32), and the result register is loaded unless the output stalls.
// One word at a time: one RAM read per probe sets the pace, and a new word waits for the result.
// The slot RAM has a single read port, so the probe walk is strictly one slot a cycle.
// Reset: arst_n clears the slot valid flags (table empty) and the control state at once;
// no clearing pass, the block takes a word in the first cycle after reset.
module linear_probe_hash_table (
	input  logic       clk,
	input  logic       arst_n,
	lpht_req_if.sink   req,
	lpht_rsp_if.source rsp
);
	import lpht_pkg::*;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_LOOKUP = 2'd1;
	localparam logic [1:0] S_PROBE  = 2'd2;

	logic [1:0]            state_q;
	opcode_t               op_q;
	key_t                  key_q;
	value_t                val_q;
	idx_t                  pos_q;
	idx_t                  cnt_q;
	logic [TABLE_SIZE-1:0] valid_q;

	logic    rsp_valid_q;
	status_t status_q;
	value_t  found_q;
	slot_t   slot_q;

	logic   rd_en;
	idx_t   rd_addr;
	entry_t rd_data;
	logic   wr_en;
	entry_t wr_data;

	logic   req_acc;
	logic   out_free;
	idx_t   pos_next;
	logic   slot_empty;
	logic   slot_used;
	logic   key_match;
	logic   op_bad;
	logic   last_probe;
	logic   stop;
	logic   done;
	status_t res_status;
	value_t  res_value;
	slot_t   res_slot;

	lpht_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_SIZE)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (pos_q),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	assign req.ready = (state_q == S_IDLE);
	assign req_acc   = req.valid && req.ready;
	assign out_free  = !rsp_valid_q || rsp.ready;

	assign pos_next   = (pos_q == idx_t'(TABLE_SIZE - 1)) ? '0 : pos_q + 1'b1;
	assign slot_empty = !valid_q[pos_q];
	assign slot_used  = valid_q[pos_q] && !rd_data.tomb;
	assign key_match  = slot_used && (rd_data.key == key_q);
	assign op_bad     = (op_q != OP_INSERT) && (op_q != OP_SEARCH) && (op_q != OP_DELETE);
	assign last_probe = (cnt_q == idx_t'(TABLE_SIZE - 1));

	// probe outcome for the slot whose data sits on the RAM output
	always_comb begin
		stop       = 1'b0;
		res_status = ST_MISS;
		res_value  = '0;
		res_slot   = '0;
		wr_en      = 1'b0;
		wr_data    = rd_data;
		if (op_bad) begin
			stop = 1'b1;
		end else if (op_q == OP_INSERT) begin
			if (!slot_used) begin
				stop       = 1'b1;
				res_status = ST_OK;
				res_slot   = slot_t'(pos_q);
				wr_en      = 1'b1;
				wr_data    = '{tomb: 1'b0, key: key_q, value: val_q};
			end
		end else if (slot_empty) begin
			stop = 1'b1;
		end else if (key_match) begin
			stop       = 1'b1;
			res_status = ST_OK;
			res_value  = rd_data.value;
			res_slot   = slot_t'(pos_q);
			if (op_q == OP_DELETE) begin
				wr_en        = 1'b1;
				wr_data.tomb = 1'b1;
			end
		end
		if (!stop && last_probe) begin
			res_status = ST_FULL;
		end
		done = (state_q == S_PROBE) && (stop || last_probe);
		// hold the write until the result can be loaded
		wr_en = wr_en && done && out_free;
	end

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = pos_q;
		if (state_q == S_LOOKUP) begin
			rd_en = 1'b1;
		end else if (state_q == S_PROBE && !done) begin
			rd_en   = 1'b1;
			rd_addr = pos_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_acc) begin
						state_q <= S_LOOKUP;
					end
				end
				S_LOOKUP: begin
					cnt_q   <= '0;
					state_q <= S_PROBE;
				end
				S_PROBE: begin
					if (done) begin
						if (out_free) begin
							state_q <= S_IDLE;
						end
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (wr_en) begin
				valid_q[pos_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			op_q  <= req.opcode;
			key_q <= req.search_key;
			val_q <= req.entry_value;
			pos_q <= idx_t'(req.search_key % TABLE_SIZE);
		end else if (state_q == S_PROBE && !done) begin
			pos_q <= pos_next;
		end
	end

	// result register: parts the probe engine from the consumer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (done && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done && out_free) begin
			status_q <= res_status;
			found_q  <= res_value;
			slot_q   <= res_slot;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = status_q;
	assign rsp.found_value = found_q;
	assign rsp.slot_index  = slot_q;

endmodule

[src/lpht_checker.sv]
module lpht_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	input  logic             req_ready,
	input  logic             rsp_valid,
	input  logic             rsp_ready,
	input  lpht_pkg::status_t status,
	input  lpht_pkg::value_t  found_value,
	input  lpht_pkg::slot_t   slot_index
);
	import lpht_pkg::*;

	// a stalled result word stays offered
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result word dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(status) && $stable(found_value)
			&& $stable(slot_index))
		else $error("result word changed while stalled");

	// one operation in flight: no new word straight after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while an operation is in flight");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != ST_OK |-> found_value == '0 && slot_index == '0)
		else $error("failed operation reports a value or slot");

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.status      (rsp.status),
	.found_value (rsp.found_value),
	.slot_index  (rsp.slot_index)
);

[bench/lpht_table_checker.sv]
`timescale 1ns / 100ps

module lpht_table_checker (
	input  logic clk,
	input  logic arst_n,
	lpht_req_if  req,
	lpht_rsp_if  rsp,
	output int   mismatches,
	output int   awaited
);
	import lpht_pkg::*;

	typedef enum logic [1:0] {SLOT_EMPTY, SLOT_USED, SLOT_TOMB} slot_mark_t;

	typedef struct packed {
		status_t status;
		value_t  value;
		slot_t   slot;
	} reply_t;

	slot_mark_t marks [TABLE_SIZE];
	key_t       keys  [TABLE_SIZE];
	value_t     vals  [TABLE_SIZE];
	reply_t     awaited_replies [$];
	int         errs;

	// Walk the probe path from the home slot and update the shadow table.
	function automatic reply_t apply_op(opcode_t op, key_t key, value_t val);
		idx_t   pos;
		reply_t r;
		pos      = idx_t'(key % TABLE_SIZE);
		r        = '0;
		r.status = ST_MISS;
		if (op != OP_INSERT && op != OP_SEARCH && op != OP_DELETE)
			return r;
		for (int n = 0; n < TABLE_SIZE; n++) begin
			if (op == OP_INSERT) begin
				if (marks[pos] != SLOT_USED) begin
					marks[pos] = SLOT_USED;
					keys[pos]  = key;
					vals[pos]  = val;
					r.status   = ST_OK;
					r.slot     = slot_t'(pos);
					return r;
				end
			end else begin
				if (marks[pos] == SLOT_EMPTY)
					return r;
				if (marks[pos] == SLOT_USED && keys[pos] == key) begin
					if (op == OP_DELETE)
						marks[pos] = SLOT_TOMB;
					r.status = ST_OK;
					r.value  = vals[pos];
					r.slot   = slot_t'(pos);
					return r;
				end
			end
			pos = (pos == idx_t'(TABLE_SIZE - 1)) ? '0 : pos + 1'b1;
		end
		r.status = ST_FULL;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		if (!arst_n) begin
			for (int i = 0; i < TABLE_SIZE; i++) begin
				marks[i] = SLOT_EMPTY;
				keys[i]  = '0;
				vals[i]  = '0;
			end
			awaited_replies.delete();
			errs = 0;
			mismatches <= 0;
			awaited    <= 0;
		end else begin
			// results leave long after their word came in, so check before predicting
			if (rsp.valid && rsp.ready) begin
				if (awaited_replies.size() == 0) begin
					errs++;
					if (errs <= 10)
						$display("%0t: result word with none awaited: status %0d value %h slot %0d",
							$realtime, rsp.status, rsp.found_value, rsp.slot_index);
				end else begin
					want = awaited_replies.pop_front();
					if (rsp.status !== want.status || rsp.found_value !== want.value ||
						rsp.slot_index !== want.slot) begin
						errs++;
						if (errs <= 10)
							$display("%0t: result mismatch: status %0d/%0d value %h/%h slot %0d/%0d (exp/act)",
								$realtime, want.status, rsp.status, want.value, rsp.found_value,
								want.slot, rsp.slot_index);
					end
				end
			end
			if (req.valid && req.ready)
				awaited_replies.push_back(apply_op(req.opcode, req.search_key, req.entry_value));
			mismatches <= errs;
			awaited    <= awaited_replies.size();
		end
	end

endmodule

[bench/linear_probe_hash_table_tb.sv]
`timescale 1ns / 100ps

module linear_probe_hash_table_tb;
	import lpht_pkg::*;

	localparam opcode_t OP_UNUSED   = 2'd3;
	localparam int      STALL_LIMIT = 4000;
	localparam int      HOLD_CYCLES = 300;
	localparam int      PHASE_WORDS = 530;
	localparam int      SETTLE      = 40;

	logic   clk    = 1'b0;
	logic   arst_n = 1'b0;
	int     req_gap_pct;
	int     rsp_gap_pct;
	bit     hold_go;
	bit     hold_used;
	int     hold_left;
	int     quiet_cycles;
	int     mismatches;
	int     awaited;
	key_t   key_pool [$];

	lpht_req_if req ();
	lpht_rsp_if rsp ();

	linear_probe_hash_table uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	lpht_table_checker watch (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.rsp        (rsp),
		.mismatches (mismatches),
		.awaited    (awaited)
	);

	always #2 clk = ~clk;

	// result side: random back-pressure, plus one long hold-off when asked
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else if (hold_left > 0) begin
			rsp.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_go && !hold_used) begin
			rsp.ready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			hold_used <= 1'b1;
		end else begin
			rsp.ready <= ($urandom_range(99) >= rsp_gap_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= STALL_LIMIT) begin
				$display("linear_probe_hash_table verification failed");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	task automatic send_word(input opcode_t op, input key_t key, input value_t val);
		while ($urandom_range(99) < req_gap_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid       <= 1'b1;
		req.opcode      <= op;
		req.search_key  <= key;
		req.entry_value <= val;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		if (op == OP_INSERT) begin
			key_pool.push_back(key);
			if (key_pool.size() > 40)
				void'(key_pool.pop_front());
		end
	endtask

	// hold the input quiet until every awaited result word has left
	task automatic drain();
		req.valid <= 1'b0;
		@(posedge clk);
		wait (awaited == 0);
		@(posedge clk);
	endtask

	// mostly keys already stored, then keys crowding home slots 0..7 and 31 around the wrap, else random keys
	function automatic key_t pick_key();
		int r;
		r = $urandom_range(99);
		if (r < 55 && key_pool.size() > 0)
			return key_pool[$urandom_range(key_pool.size() - 1)];
		if (r < 85)
			return {(KEY_W - IDX_W)'($urandom),
				($urandom_range(1) ? idx_t'(TABLE_SIZE - 1) : idx_t'($urandom_range(7)))};
		return key_t'($urandom);
	endfunction

	function automatic opcode_t pick_op(bit fill_bias);
		int r;
		r = $urandom_range(99);
		if (r < 3)
			return OP_UNUSED;
		if (r < (fill_bias ? 58 : 23))
			return OP_INSERT;
		if (r < (fill_bias ? 78 : 53))
			return OP_SEARCH;
		return OP_DELETE;
	endfunction

	task automatic run_random(input int count, input int req_pct, input int rsp_pct);
		req_gap_pct <= req_pct;
		rsp_gap_pct <= rsp_pct;
		// alternate draining and filling stretches; start by draining, whose deletes leave tombstones for inserts
		for (int i = 0; i < count; i++)
			send_word(pick_op(((i / 48) % 2) == 1), pick_key(), value_t'($urandom));
	endtask

	initial begin
		req.valid       <= 1'b0;
		req.opcode      <= OP_INSERT;
		req.search_key  <= '0;
		req.entry_value <= '0;
		req_gap_pct     <= 32;
		rsp_gap_pct     <= 81;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		send_word(OP_SEARCH, 16'h0000, 32'h0000_0000);
		send_word(OP_DELETE, 16'hFFFF, 32'hFFFF_FFFF);
		send_word(OP_UNUSED, 16'h1234, 32'h1234_5678);
		send_word(OP_INSERT, 16'h0000, 32'h0000_0000);
		send_word(OP_INSERT, 16'hFFFF, 32'hFFFF_FFFF);
		// home slot is the last one, so this wraps past slot 0
		send_word(OP_INSERT, 16'h001F, 32'hA5A5_A5A5);
		send_word(OP_SEARCH, 16'h001F, 32'h0000_0000);
		send_word(OP_INSERT, 16'h0000, 32'h5A5A_5A5A);
		send_word(OP_DELETE, 16'h0000, 32'hFFFF_FFFF);
		// must step over the tombstone to the duplicate
		send_word(OP_SEARCH, 16'h0000, 32'h0000_0000);
		send_word(OP_INSERT, 16'h0020, 32'h0000_FFFF);
		send_word(OP_SEARCH, 16'h0040, 32'h0000_0000);
		send_word(OP_DELETE, 16'hFFFF, 32'h0000_0000);
		send_word(OP_SEARCH, 16'hFFFF, 32'h0000_0000);
		send_word(OP_INSERT, 16'h8000, 32'h8000_0000);
		send_word(OP_UNUSED, 16'hFFFF, 32'hFFFF_FFFF);
		send_word(OP_DELETE, 16'h001F, 32'h0000_0000);
		drain();

		run_random(PHASE_WORDS, 32, 81);
		drain();
		run_random(PHASE_WORDS, 81, 32);
		drain();
		hold_go <= 1'b1;
		run_random(PHASE_WORDS, 0, 0);
		drain();

		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0 && awaited == 0)
			$display("linear_probe_hash_table verification clean");
		else
			$display("linear_probe_hash_table verification failed");
		$finish;
	end

endmodule
